// ===== rtl/apa_pkg.sv =====
// Shared constants, types and helpers for the antenna pointing angle pipeline.
// No dependencies; the files that use it refer to it by scoped names.
package apa_pkg;

    localparam int CORDIC_STAGES = 24;

    localparam int QW  = 36;  // Q30 product word
    localparam int SCW = 34;  // sin/cos CORDIC word
    localparam int ATW = 44;  // atan2 CORDIC word after normalization
    localparam int ZW  = 34;  // binary-angle accumulator
    localparam int SQ_STAGES = 31;

    localparam logic [1:0] CFG_STATION_LAT = 2'd0;
    localparam logic [1:0] CFG_STATION_LON = 2'd1;
    localparam logic [1:0] CFG_STATION_ALT = 2'd2;

    localparam logic signed [SCW-1:0] CORDIC_GAIN   = 34'sd652032874;
    localparam logic [32:0]           PI_Q31        = 33'd6746518852;
    localparam logic [22:0]           EARTH_RADIUS_M = 23'd6371000;
    localparam logic [8:0]            FULL_DEG      = 9'd360;
    localparam logic [7:0]            HALF_DEG      = 8'd180;
    localparam logic [30:0]           ONE_Q30       = 31'd1073741824;

    localparam logic [31:0] ATAN_BA [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef logic signed [QW-1:0] t_q;

    // Q30 product, floored back to Q30
    function automatic t_q mul_q30(input t_q a, input t_q b);
        logic signed [2*QW-1:0] p;
        p = a * b;
        return t_q'(p >>> 30);
    endfunction

    function automatic int at_latency(input int n);
        return n + 8;
    endfunction

    function automatic int sc_latency(input int n);
        return n + 2;
    endfunction

    function automatic int top_latency(input int n);
        return 3 * n + 56;
    endfunction

endpackage

// ===== rtl/apa_delay.sv =====
// Fixed-length shift line that carries a data word alongside the pipeline.
// Depends on nothing.
module apa_delay #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_sr [D];

    always_ff @(posedge i_clk) begin
        r_sr[0] <= i_d;
    end

    for (genvar k = 1; k < D; k++) begin : g_tap
        always_ff @(posedge i_clk) begin
            r_sr[k] <= r_sr[k-1];
        end
    end

    assign o_q = r_sr[D-1];
endmodule

// ===== rtl/apa_sincos.sv =====
// Pipelined rotation CORDIC: sin and cos in Q30 of a 32-bit binary angle.
// Depends on apa_pkg.
module apa_sincos #(
    parameter int STAGES = apa_pkg::CORDIC_STAGES
) (
    input  logic          i_clk,
    input  logic [31:0]   i_ang,
    output apa_pkg::t_q   o_sin,
    output apa_pkg::t_q   o_cos
);
    localparam int W = apa_pkg::SCW;
    localparam logic signed [W-1:0] QUARTER = W'(64'sd1073741824);
    localparam logic signed [W-1:0] HALF    = W'(64'sd2147483648);

    logic signed [W-1:0] r_x [STAGES+1];
    logic signed [W-1:0] r_y [STAGES+1];
    logic signed [W-1:0] r_t [STAGES+1];
    logic                r_neg [STAGES+1];
    logic signed [W-1:0] r_s, r_c;
    logic signed [W-1:0] n_t, n_a;
    logic                n_neg;

    // fold into +-90 deg
    always_comb begin
        n_a   = W'($signed(i_ang));
        n_t   = n_a;
        n_neg = 1'b0;
        if (n_a > QUARTER) begin
            n_t   = n_a - HALF;
            n_neg = 1'b1;
        end else if (n_a < -QUARTER) begin
            n_t   = n_a + HALF;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t[0]   <= n_t;
        r_x[0]   <= apa_pkg::CORDIC_GAIN;
        r_y[0]   <= '0;
        r_neg[0] <= n_neg;
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        localparam logic signed [W-1:0] A = W'($signed({1'b0, apa_pkg::ATAN_BA[i]}));
        always_ff @(posedge i_clk) begin
            r_neg[i+1] <= r_neg[i];
            if (r_t[i] >= 0) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_t[i+1] <= r_t[i] - A;
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_t[i+1] <= r_t[i] + A;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= r_neg[STAGES] ? -r_y[STAGES] : r_y[STAGES];
        r_c <= r_neg[STAGES] ? -r_x[STAGES] : r_x[STAGES];
    end

    assign o_sin = apa_pkg::t_q'(r_s);
    assign o_cos = apa_pkg::t_q'(r_c);
endmodule

// ===== rtl/apa_atan2.sv =====
// Pipelined vectoring CORDIC atan2 with a six-step normalizing shifter.
// Depends on apa_pkg.
module apa_atan2 #(
    parameter int STAGES = apa_pkg::CORDIC_STAGES
) (
    input  logic                            i_clk,
    input  apa_pkg::t_q                     i_y,
    input  apa_pkg::t_q                     i_x,
    output logic signed [apa_pkg::ZW-1:0]   o_z
);
    localparam int W  = apa_pkg::ATW;
    localparam int ZW = apa_pkg::ZW;
    localparam logic signed [ZW-1:0] Z_HALF = ZW'(64'sd2147483648);

    logic signed [W-1:0] r_x [7];
    logic signed [W-1:0] r_y [7];
    logic        [W-1:0] r_m [7];
    logic                r_zero [7];

    logic signed [W-1:0] r_vx [STAGES+1];
    logic signed [W-1:0] r_vy [STAGES+1];
    logic signed [ZW-1:0] r_vz [STAGES+1];
    logic                 r_vzero [STAGES+1];

    logic signed [W-1:0] n_x, n_y, n_ax, n_ay;

    always_comb begin
        n_x  = W'(i_x);
        n_y  = W'(i_y);
        n_ax = (n_x < 0) ? -n_x : n_x;
        n_ay = (n_y < 0) ? -n_y : n_y;
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= n_x;
        r_y[0]    <= n_y;
        r_m[0]    <= (n_ay > n_ax) ? n_ay : n_ax;
        r_zero[0] <= (n_x == 0) && (n_y == 0);
    end

    // shift left by 32,16,..,1 until the larger magnitude reaches 2^40
    for (genvar s = 0; s < 6; s++) begin : g_norm
        localparam int K = 32 >> s;
        localparam logic [W-1:0] LIM = W'(1) << (41 - K);
        always_ff @(posedge i_clk) begin
            r_zero[s+1] <= r_zero[s];
            if (r_m[s] < LIM) begin
                r_x[s+1] <= r_x[s] <<< K;
                r_y[s+1] <= r_y[s] <<< K;
                r_m[s+1] <= r_m[s] << K;
            end else begin
                r_x[s+1] <= r_x[s];
                r_y[s+1] <= r_y[s];
                r_m[s+1] <= r_m[s];
            end
        end
    end

    // left half-plane: turn by 180 deg
    always_ff @(posedge i_clk) begin
        r_vzero[0] <= r_zero[6];
        if (r_x[6] < 0) begin
            r_vx[0] <= -r_x[6];
            r_vy[0] <= -r_y[6];
            r_vz[0] <= (r_y[6] >= 0) ? Z_HALF : -Z_HALF;
        end else begin
            r_vx[0] <= r_x[6];
            r_vy[0] <= r_y[6];
            r_vz[0] <= '0;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_vec
        localparam logic signed [ZW-1:0] A = ZW'($signed({1'b0, apa_pkg::ATAN_BA[i]}));
        always_ff @(posedge i_clk) begin
            r_vzero[i+1] <= r_vzero[i];
            if (r_vy[i] > 0) begin
                r_vx[i+1] <= r_vx[i] + (r_vy[i] >>> i);
                r_vy[i+1] <= r_vy[i] - (r_vx[i] >>> i);
                r_vz[i+1] <= r_vz[i] + A;
            end else begin
                r_vx[i+1] <= r_vx[i] - (r_vy[i] >>> i);
                r_vy[i+1] <= r_vy[i] + (r_vx[i] >>> i);
                r_vz[i+1] <= r_vz[i] - A;
            end
        end
    end

    assign o_z = r_vzero[STAGES] ? '0 : r_vz[STAGES];
endmodule

// ===== rtl/apa_isqrt.sv =====
// Pipelined floor square root of a Q30 value shifted up to Q60, one root bit per stage.
// Depends on apa_pkg.
module apa_isqrt (
    input  logic        i_clk,
    input  logic [30:0] i_a,
    output logic [30:0] o_root
);
    localparam int W = 62;
    localparam int N = apa_pkg::SQ_STAGES;

    logic [W-1:0] r_v [N];
    logic [W-1:0] r_r [N];

    for (genvar k = 0; k < N; k++) begin : g_bit
        localparam logic [W-1:0] B = W'(1) << (60 - 2 * k);
        logic [W-1:0] cur_v, cur_r, sum;
        if (k == 0) begin : g_first
            assign cur_v = W'({i_a, 30'b0});
            assign cur_r = '0;
        end else begin : g_next
            assign cur_v = r_v[k-1];
            assign cur_r = r_r[k-1];
        end
        assign sum = cur_r + B;
        always_ff @(posedge i_clk) begin
            if (cur_v >= sum) begin
                r_v[k] <= cur_v - sum;
                r_r[k] <= (cur_r >> 1) + B;
            end else begin
                r_v[k] <= cur_v;
                r_r[k] <= cur_r >> 1;
            end
        end
    end

    assign o_root = r_r[N-1][30:0];
endmodule

// ===== rtl/antenna_pointing_angles.sv =====
// Top level: antenna pointing angles from a target fix and the station registers.
// Depends on apa_pkg, apa_delay, apa_sincos, apa_isqrt and apa_atan2.
//
// Usage
//   Station position: write station latitude, longitude and altitude through
//   i_cfg_we / i_cfg_idx / i_cfg_wdata while no fix is in flight. Writes take
//   effect at the clock edge; indexes past the last register are ignored.
//   Input: a fix (latitude, longitude, altitude) is taken at every rising edge
//   where start is high and busy is low. busy never rises, so a new word can
//   be issued every cycle.
//   Output: each fix yields one result word, shown for exactly one cycle with
//   o_strobe high: azimuth and elevation in whole degrees, pan and tilt servo
//   angles. Results leave in the order fixes came in.
//   Throughput: one word per cycle. The latency is set by the elevation
//   path: the sin/cos bank, the 31-stage square root and two CORDIC atan2
//   passes in series (half arc, then elevation). The azimuth atan2 runs
//   alongside and is delayed to line up.
//   Reset (synchronous, active low) clears the station registers and the
//   valid line, so nothing in flight is reported afterwards.
//   The receiver has no way to hold results off: o_strobe marks the only
//   cycle a result is visible.
module antenna_pointing_angles #(
    parameter int CORDIC_STAGES = apa_pkg::CORDIC_STAGES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_wdata,
    input  logic              start,
    output logic              busy,
    input  logic signed [31:0] i_target_latitude,
    input  logic signed [31:0] i_target_longitude,
    input  logic signed [31:0] i_target_altitude,
    output logic              o_strobe,
    output logic [8:0]        o_azimuth_degrees,
    output logic signed [7:0] o_elevation_degrees,
    output logic [7:0]        o_pan_angle,
    output logic [7:0]        o_tilt_angle
);
    localparam int N      = CORDIC_STAGES;
    localparam int LAT    = apa_pkg::top_latency(N);
    localparam int D_AZ   = apa_pkg::at_latency(N) + 33;
    localparam int D_DALT = apa_pkg::sc_latency(N) + apa_pkg::at_latency(N) + 35;
    localparam int ZW     = apa_pkg::ZW;
    localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(64'sd1073741824);

    // station registers
    logic signed [31:0] r_st_lat, r_st_lon, r_st_alt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_lat <= '0;
            r_st_lon <= '0;
            r_st_alt <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                apa_pkg::CFG_STATION_LAT: r_st_lat <= i_cfg_wdata;
                apa_pkg::CFG_STATION_LON: r_st_lon <= i_cfg_wdata;
                apa_pkg::CFG_STATION_ALT: r_st_alt <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // valid line, one bit per pipeline slot
    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    // stage 0: angle differences
    logic [31:0]        r_lat1, r_lat2, r_dlon, r_hlat, r_hlon;
    logic signed [32:0] r_dalt;
    logic signed [32:0] n_dlat, n_dlon;

    assign n_dlat = 33'(i_target_latitude) - 33'(r_st_lat);
    assign n_dlon = 33'(i_target_longitude) - 33'(r_st_lon);

    always_ff @(posedge i_clk) begin
        r_lat1 <= r_st_lat;
        r_lat2 <= i_target_latitude;
        r_dlon <= n_dlon[31:0];
        r_hlat <= n_dlat[32:1];
        r_hlon <= n_dlon[32:1];
        r_dalt <= 33'(i_target_altitude) - 33'(r_st_alt);
    end

    // sin/cos bank
    apa_pkg::t_q sl1, cl1, sl2, cl2, sdl, cdl, s1, s2;

    apa_sincos #(.STAGES(N)) u_sc_lat1 (.i_clk, .i_ang(r_lat1), .o_sin(sl1), .o_cos(cl1));
    apa_sincos #(.STAGES(N)) u_sc_lat2 (.i_clk, .i_ang(r_lat2), .o_sin(sl2), .o_cos(cl2));
    apa_sincos #(.STAGES(N)) u_sc_dlon (.i_clk, .i_ang(r_dlon), .o_sin(sdl), .o_cos(cdl));
    apa_sincos #(.STAGES(N)) u_sc_hlat (.i_clk, .i_ang(r_hlat), .o_sin(s1), .o_cos());
    apa_sincos #(.STAGES(N)) u_sc_hlon (.i_clk, .i_ang(r_hlon), .o_sin(s2), .o_cos());

    // products, first rank
    apa_pkg::t_q r_yv1, r_p1, r_p2, r_ss1, r_ss2, r_cc, r_cdl;

    always_ff @(posedge i_clk) begin
        r_yv1 <= apa_pkg::mul_q30(sdl, cl2);
        r_p1  <= apa_pkg::mul_q30(cl1, sl2);
        r_p2  <= apa_pkg::mul_q30(sl1, cl2);
        r_ss1 <= apa_pkg::mul_q30(s1, s1);
        r_ss2 <= apa_pkg::mul_q30(s2, s2);
        r_cc  <= apa_pkg::mul_q30(cl1, cl2);
        r_cdl <= cdl;
    end

    // products, second rank: bearing operands and clamped haversine term
    apa_pkg::t_q r_xv, r_yv, n_asum;
    logic [30:0] r_a, r_b, n_a;

    always_comb begin
        n_asum = r_ss1 + apa_pkg::mul_q30(r_cc, r_ss2);
        if (n_asum < 0) begin
            n_a = '0;
        end else if (n_asum > apa_pkg::t_q'(apa_pkg::ONE_Q30)) begin
            n_a = apa_pkg::ONE_Q30;
        end else begin
            n_a = n_asum[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_xv <= r_p1 - apa_pkg::mul_q30(r_p2, r_cdl);
        r_yv <= r_yv1;
        r_a  <= n_a;
        r_b  <= apa_pkg::ONE_Q30 - n_a;
    end

    // azimuth branch
    logic signed [ZW-1:0] z_az;
    logic [40:0]          n_az_prod;
    logic [8:0]           r_az_deg, az_deg_d;

    apa_atan2 #(.STAGES(N)) u_at_az (.i_clk, .i_y(r_yv), .i_x(r_xv), .o_z(z_az));

    assign n_az_prod = 41'(z_az[31:0]) * 41'(apa_pkg::FULL_DEG);

    always_ff @(posedge i_clk) begin
        r_az_deg <= n_az_prod[40:32];
    end

    apa_delay #(.W(9), .D(D_AZ)) u_dly_az (.i_clk, .i_d(r_az_deg), .o_q(az_deg_d));

    // haversine central angle and ground distance
    logic [30:0]          sa, sb;
    logic signed [ZW-1:0] z_ch;
    logic [30:0]          n_ch;
    logic [64:0]          n_arc_prod;
    logic [31:0]          r_arc;
    logic [54:0]          n_dist_prod;
    logic [32:0]          r_dist;

    apa_isqrt u_sq_a (.i_clk, .i_a(r_a), .o_root(sa));
    apa_isqrt u_sq_b (.i_clk, .i_a(r_b), .o_root(sb));

    apa_atan2 #(.STAGES(N)) u_at_ch (
        .i_clk,
        .i_y(apa_pkg::t_q'(sa)),
        .i_x(apa_pkg::t_q'(sb)),
        .o_z(z_ch)
    );

    // half arc clamped to 0..90 deg
    always_comb begin
        if (z_ch < 0) begin
            n_ch = '0;
        end else if (z_ch > Z_QUARTER) begin
            n_ch = 31'(Z_QUARTER);
        end else begin
            n_ch = z_ch[30:0];
        end
    end

    assign n_arc_prod  = 65'({n_ch, 1'b0}) * 65'(apa_pkg::PI_Q31);
    assign n_dist_prod = 55'(r_arc) * 55'(apa_pkg::EARTH_RADIUS_M);

    always_ff @(posedge i_clk) begin
        r_arc  <= n_arc_prod[63:32];
        r_dist <= n_dist_prod[54:22];
    end

    // elevation
    logic [32:0]          dalt_d;
    logic signed [ZW-1:0] z_el;

    apa_delay #(.W(33), .D(D_DALT)) u_dly_dalt (.i_clk, .i_d(r_dalt), .o_q(dalt_d));

    apa_atan2 #(.STAGES(N)) u_at_el (
        .i_clk,
        .i_y(apa_pkg::t_q'($signed(dalt_d))),
        .i_x(apa_pkg::t_q'(r_dist)),
        .o_z(z_el)
    );

    logic [30:0]       n_mag;
    logic [38:0]       n_el_prod;
    logic [7:0]        n_deg;
    logic              n_el_neg;
    logic signed [7:0] r_el_deg;
    logic [7:0]        r_tilt;

    always_comb begin
        n_el_neg = z_el < 0;
        if (z_el > Z_QUARTER || z_el < -Z_QUARTER) begin
            n_mag = 31'(Z_QUARTER);
        end else if (n_el_neg) begin
            n_mag = 31'(-z_el);
        end else begin
            n_mag = z_el[30:0];
        end
        n_el_prod = 39'(n_mag) * 39'(apa_pkg::HALF_DEG);
        n_deg     = n_el_prod[38:31];
    end

    always_ff @(posedge i_clk) begin
        r_el_deg <= n_el_neg ? -$signed(n_deg) : $signed(n_deg);
        r_tilt   <= n_el_neg ? 8'd0 : {n_deg[6:0], 1'b0};
    end

    // result register
    logic [8:0]        r_o_az;
    logic signed [7:0] r_o_el;
    logic [7:0]        r_o_pan, r_o_tilt;

    always_ff @(posedge i_clk) begin
        r_o_az   <= az_deg_d;
        r_o_pan  <= 8'(az_deg_d >> 1);
        r_o_el   <= r_el_deg;
        r_o_tilt <= r_tilt;
    end

    assign o_strobe            = r_vld[LAT-1];
    assign o_azimuth_degrees   = r_o_az;
    assign o_elevation_degrees = r_o_el;
    assign o_pan_angle         = r_o_pan;
    assign o_tilt_angle        = r_o_tilt;
endmodule

// ===== rtl/apa_chk.sv =====
// Port-level checker for antenna_pointing_angles, attached by bind.
// Depends on apa_pkg.
module apa_chk #(
    parameter int CORDIC_STAGES = apa_pkg::CORDIC_STAGES
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_strobe,
    input logic [8:0]        o_azimuth_degrees,
    input logic signed [7:0] o_elevation_degrees,
    input logic [7:0]        o_pan_angle,
    input logic [7:0]        o_tilt_angle
);
    localparam int LAT = apa_pkg::top_latency(CORDIC_STAGES);

    a_no_strobe_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe) else $error("strobe right after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT)) else $error("result without a word");

    a_azimuth_pan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_azimuth_degrees <= 9'd359) &&
                     (o_pan_angle == 8'(o_azimuth_degrees >> 1)))
        else $error("azimuth or pan out of line");

    a_elev_tilt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_elevation_degrees >= -8'sd90) && (o_elevation_degrees <= 8'sd90) &&
                     ((o_elevation_degrees[7] && o_tilt_angle == 8'd0) ||
                      (!o_elevation_degrees[7] &&
                       o_tilt_angle == {o_elevation_degrees[6:0], 1'b0})))
        else $error("elevation or tilt out of line");
endmodule

bind antenna_pointing_angles apa_chk #(.CORDIC_STAGES(CORDIC_STAGES)) u_apa_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .start(start),
    .busy(busy),
    .o_strobe(o_strobe),
    .o_azimuth_degrees(o_azimuth_degrees),
    .o_elevation_degrees(o_elevation_degrees),
    .o_pan_angle(o_pan_angle),
    .o_tilt_angle(o_tilt_angle)
);

// ===== bench/tb_antenna_pointing_angles.sv =====
// Testbench for antenna_pointing_angles: bearing and elevation from a target fix.
// Depends on apa_pkg and the antenna_pointing_angles RTL; needs nothing else.
module tb_antenna_pointing_angles;

    localparam int STAGES  = apa_pkg::CORDIC_STAGES;
    localparam int LATENCY = apa_pkg::top_latency(STAGES);
    localparam int PHASE_WORDS = 150;

    // Pointing predictor plus the queue of pending pointing results.
    class pointing_board;
        longint station_lat, station_lon, station_alt;
        logic [32:0] pending_q[$];  // {az, el, pan, tilt} packed below
        int unsigned n_checked, n_errors;

        function new();
            station_lat = 0;
            station_lon = 0;
            station_alt = 0;
            n_checked = 0;
            n_errors = 0;
        endfunction

        function void set_station(logic [1:0] idx, logic [31:0] value);
            if (idx == apa_pkg::CFG_STATION_LAT) station_lat = longint'(signed'(value));
            else if (idx == apa_pkg::CFG_STATION_LON) station_lon = longint'(signed'(value));
            else if (idx == apa_pkg::CFG_STATION_ALT) station_alt = longint'(signed'(value));
        endfunction

        // rotation CORDIC, angle folded into +-90 deg
        function void rotate_sincos(logic [31:0] ang, output longint s, output longint c);
            longint t, x, y, dx, dy;
            bit flip;
            t = longint'(signed'(ang));
            flip = 0;
            x = 652032874;
            y = 0;
            if (t > 64'sd1073741824) begin
                t -= 64'sd2147483648;
                flip = 1;
            end else if (t < -64'sd1073741824) begin
                t += 64'sd2147483648;
                flip = 1;
            end
            for (int i = 0; i < STAGES && i < 32; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (t >= 0) begin
                    x -= dx; y += dy; t -= longint'(apa_pkg::ATAN_BA[i]);
                end else begin
                    x += dx; y -= dy; t += longint'(apa_pkg::ATAN_BA[i]);
                end
            end
            s = flip ? -y : y;
            c = flip ? -x : x;
        endfunction

        // vectoring CORDIC, operands normalized to at least 2^40
        function longint vector_angle(longint y, longint x);
            longint z, m, ay, ax, dx, dy;
            if (x == 0 && y == 0) return 0;
            ay = (y < 0) ? -y : y;
            ax = (x < 0) ? -x : x;
            m = (ay > ax) ? ay : ax;
            z = 0;
            while (m < 64'sd1099511627776) begin
                x *= 2; y *= 2; m *= 2;
            end
            if (x < 0) begin
                z = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < STAGES && i < 32; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x += dx; y -= dy; z += longint'(apa_pkg::ATAN_BA[i]);
                end else begin
                    x -= dx; y += dy; z -= longint'(apa_pkg::ATAN_BA[i]);
                end
            end
            return z;
        endfunction

        function longint unsigned floor_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // note an accepted fix: predict its pointing word
        function void note_fix(logic [31:0] lat_in, logic [31:0] lon_in, logic [31:0] alt_in);
            longint lat2, lon2, alt2, sl1, cl1, sl2, cl2, sdl, cdl, s1, s2, junk;
            longint yv, xv, zaz, hav, ch, ze, mag, az, el, pan, tilt;
            longint unsigned sa, sb, c, arc, gnd_dist, wide;
            lat2 = longint'(signed'(lat_in));
            lon2 = longint'(signed'(lon_in));
            alt2 = longint'(signed'(alt_in));
            // bearing
            rotate_sincos(station_lat[31:0], sl1, cl1);
            rotate_sincos(lat2[31:0], sl2, cl2);
            rotate_sincos(32'(lon2 - station_lon), sdl, cdl);
            yv = (sdl * cl2) >>> 30;
            xv = ((cl1 * sl2) >>> 30) - ((((sl1 * cl2) >>> 30) * cdl) >>> 30);
            zaz = vector_angle(yv, xv);
            wide = {32'd0, zaz[31:0]} * 64'd360;
            az = longint'(wide >> 32);
            // haversine ground distance
            rotate_sincos(32'((lat2 - station_lat) >>> 1), s1, junk);
            rotate_sincos(32'((lon2 - station_lon) >>> 1), s2, junk);
            hav = ((s1 * s1) >>> 30) + ((((cl1 * cl2) >>> 30) * ((s2 * s2) >>> 30)) >>> 30);
            if (hav < 0) hav = 0;
            if (hav > 64'sd1073741824) hav = 64'sd1073741824;
            sa = floor_sqrt(longint'(hav) << 30);
            sb = floor_sqrt(longint'(64'sd1073741824 - hav) << 30);
            ch = vector_angle(longint'(sa), longint'(sb));
            if (ch < 0) ch = 0;
            if (ch > 64'sd1073741824) ch = 64'sd1073741824;
            c = longint'(ch) * 2;
            arc = (c * 64'd6746518852) >> 32;
            gnd_dist = (arc * 64'd6371000) >> 22;
            // elevation, clamped to +-90 deg
            ze = vector_angle(alt2 - station_alt, longint'(gnd_dist));
            if (ze > 64'sd1073741824) ze = 64'sd1073741824;
            if (ze < -64'sd1073741824) ze = -64'sd1073741824;
            mag = (ze < 0) ? -ze : ze;
            el = (mag * 180) >>> 31;
            if (ze < 0) el = -el;
            pan = az * 180 / 360;
            if (pan < 0) pan = 0;
            if (pan > 180) pan = 180;
            tilt = el * 180 / 90;
            if (tilt < 0) tilt = 0;
            if (tilt > 180) tilt = 180;
            pending_q.push_back({az[8:0], el[7:0], pan[7:0], tilt[7:0]});
        endfunction

        task report(string what, int got, int want);
            n_errors++;
            $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        endtask

        // check a result word against the oldest prediction
        task check_word(logic [8:0] az, logic [7:0] el, logic [7:0] pan, logic [7:0] tilt);
            logic [32:0] w;
            if (pending_q.size() == 0) begin
                report("unexpected result word, az", az, -1);
                return;
            end
            w = pending_q.pop_front();
            n_checked++;
            if (az != w[32:24]) report("azimuth", az, w[32:24]);
            if (el != w[23:16]) report("elevation", signed'(el), signed'(w[23:16]));
            if (pan != w[15:8]) report("pan", pan, w[15:8]);
            if (tilt != w[7:0]) report("tilt", tilt, w[7:0]);
        endtask

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_cfg_we = 0;
    logic [1:0]        i_cfg_idx = '0;
    logic [31:0]       i_cfg_wdata = '0;
    logic              start = 0;
    logic              busy;
    logic signed [31:0] i_target_latitude = '0;
    logic signed [31:0] i_target_longitude = '0;
    logic signed [31:0] i_target_altitude = '0;
    logic              o_strobe;
    logic [8:0]        o_azimuth_degrees;
    logic signed [7:0] o_elevation_degrees;
    logic [7:0]        o_pan_angle;
    logic [7:0]        o_tilt_angle;

    pointing_board board = new();
    int unsigned n_fixes = 0;

    antenna_pointing_angles u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_wdata         (i_cfg_wdata),
        .start               (start),
        .busy                (busy),
        .i_target_latitude   (i_target_latitude),
        .i_target_longitude  (i_target_longitude),
        .i_target_altitude   (i_target_altitude),
        .o_strobe            (o_strobe),
        .o_azimuth_degrees   (o_azimuth_degrees),
        .o_elevation_degrees (o_elevation_degrees),
        .o_pan_angle         (o_pan_angle),
        .o_tilt_angle        (o_tilt_angle)
    );

    always #1 i_clk = ~i_clk;

    // result monitor: strobe marks the one cycle a word is visible
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            board.check_word(o_azimuth_degrees, o_elevation_degrees, o_pan_angle, o_tilt_angle);
    end

    // station register write, only while nothing is in flight
    task write_station(logic [1:0] idx, logic [31:0] value);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        board.set_station(idx, value);
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    // issue one fix and hold it until taken; returns at the next falling edge
    task send_fix(logic [31:0] lat, logic [31:0] lon, logic [31:0] alt);
        bit taken;
        start <= 1;
        i_target_latitude <= lat;
        i_target_longitude <= lon;
        i_target_altitude <= alt;
        do begin
            @(posedge i_clk);
            taken = !busy;
        end while (!taken);
        board.note_fix(lat, lon, alt);
        n_fixes++;
        @(negedge i_clk);
    endtask

    task idle_gap(int n);
        if (n > 0) begin
            start <= 0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // drain: wait for every word to be checked, then idle with start low
    task drain();
        start <= 0;
        while (board.pending() > 0) @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    // random fix: mostly near the station, sometimes anywhere, rarely off-range lat
    task random_fix();
        logic [31:0] lat, lon, alt;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 5) begin
            lat = 32'(board.station_lat + $signed($urandom_range(0, 2000000)) - 1000000);
            lon = 32'(board.station_lon + $signed($urandom_range(0, 2000000)) - 1000000);
            alt = 32'(board.station_alt + $signed($urandom_range(0, 20000000)) - 10000000);
        end else if (mode < 8) begin
            lat = 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
            lon = $urandom;
            alt = $urandom;
        end else begin
            lat = $urandom;  // off-range latitudes used as raw binary angles
            lon = $urandom;
            alt = $urandom;
        end
        send_fix(lat, lon, alt);
        // one word in three skips the idle gap; the others get a random gap, which can be empty
        if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(0, 5));
    endtask

    initial begin
        logic [31:0] stations[7][3];
        stations[0] = '{32'd0, 32'd0, 32'd0};
        stations[1] = '{32'h4000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
        stations[2] = '{32'hC000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        for (int p = 3; p < 7; p++)
            stations[p] = '{32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000),
                            $urandom, $urandom};

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: registers at reset value
        send_fix(0, 0, 0);                                 // coincident points
        send_fix(32'h4000_0000, 0, 32'h7FFF_FFFF);         // north pole, straight up
        send_fix(32'hC000_0000, 0, 32'h8000_0000);         // south pole, straight down
        send_fix(0, 32'h8000_0000, 0);                     // antipode, longitude extreme
        send_fix(0, 32'h7FFF_FFFF, 256);
        send_fix(0, 32'h4000_0000, 0);                     // due east
        send_fix(0, 32'hC000_0000, -256);                  // due west, below
        send_fix(32'h0000_0100, 0, 0);                     // tiny north offset
        send_fix(32'hFFFF_FF00, 0, 0);                     // tiny south offset
        send_fix(32'h7FFF_FFFF, 32'h1234_5678, 32'd1000);  // latitude past the pole
        send_fix(32'h8000_0000, 32'hFFFF_FFFF, -32'sd1000);
        send_fix(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
        idle_gap(3);
        send_fix(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // hold off until the pipe is empty once
        start <= 0;
        while (board.pending() > 0) @(negedge i_clk);
        send_fix(32'h2000_0000, 32'h2000_0000, 32'h0010_0000);

        for (int p = 0; p < 7; p++) begin
            drain();
            write_station(apa_pkg::CFG_STATION_LAT, stations[p][0]);
            write_station(apa_pkg::CFG_STATION_LON, stations[p][1]);
            write_station(apa_pkg::CFG_STATION_ALT, stations[p][2]);
            if (p == 1) begin
                // coincident with the station at extreme registers
                send_fix(stations[p][0], stations[p][1], stations[p][2]);
                send_fix(stations[p][0], stations[p][1], 32'h8000_0000);
            end
            for (int k = 0; k < PHASE_WORDS; k++)
                random_fix();
        end

        start <= 0;
        while (board.pending() > 0) @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
        if (board.pending() != 0) board.report("words left unchecked", board.pending(), 0);

        $display("covered %0d fixes over 7 station settings, %0d result words checked",
                 n_fixes, board.n_checked);
        $display("station registers included pole, date-line and altitude extremes");
        if (board.n_errors == 0)
            $display("** antenna_pointing_angles: PASSED **");
        else
            $display("** antenna_pointing_angles: FAILED **");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("timeout at %0t", $realtime);
        $display("** antenna_pointing_angles: FAILED **");
        $finish;
    end

endmodule
